// ----- hdl/art_pkg.sv -----
// Package for the address region table: sizes, operation and status codes,
// FSM states and the structs passed between the top level and its cells.
// No dependencies.
package art_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 48;
    localparam int PAGES_W     = 36;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int FUNC_W      = 2;
    localparam int KIND_W      = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PADDR_W     = 4;

    // Width of first + (pages << PAGE_SHIFT) including its carry.
    localparam int SPAN_W = PAGES_W + PAGE_SHIFT;
    localparam int SUM_W  = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 1;

    localparam logic [ADDR_W-1:0] PAGE_MASK =
        {{(ADDR_W-PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}};
    localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST = ADDR_W'(64'h0000_8000_0000_0000);

    localparam logic [KIND_W-1:0] KIND_MMIO = 2'd0;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_CONFLICT   = 3'd1,
        ST_UNALIGNED  = 3'd2,
        ST_HIGH_LIMIT = 3'd3,
        ST_NO_READ    = 3'd4,
        ST_FULL       = 3'd5,
        ST_SLOT_EMPTY = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } t_state;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic              cmp_en;
        t_func             func;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] vfirst;
        logic [ADDR_W-1:0] vend;
        logic [SLOT_W-1:0] slot;
    } t_bcast;

    // Table update, applied by the cell whose index matches.
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_wr;

    // Scan result handed from cell to cell along the chain.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [ADDR_W-1:0] hit_first;
        logic [ADDR_W-1:0] hit_last;
        logic              multi;
        logic              err;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
    } t_link;

endpackage

// ----- hdl/art_cell.sv -----
// One table entry of the address region table with its comparators and its
// link in the scan chain. Depends on art_pkg.
module art_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [art_pkg::SLOT_W-1:0] i_idx,
    input  art_pkg::t_bcast      i_bc,
    input  art_pkg::t_wr         i_wr,
    input  art_pkg::t_link       i_link,
    output art_pkg::t_link       o_link,
    output logic                 o_valid
);
    import art_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_first;
    logic [ADDR_W-1:0] r_last;
    logic              r_pick;
    logic              r_partial;
    logic              r_encl;

    logic in_lo;
    logic in_hi;
    logic n_pick;
    logic n_partial;
    logic n_encl;

    always_comb begin
        in_lo     = (r_first <= i_bc.lo) && (i_bc.lo <= r_last);
        in_hi     = (r_first <= i_bc.hi) && (i_bc.hi <= r_last);
        n_pick    = 1'b0;
        n_partial = 1'b0;
        n_encl    = 1'b0;
        if (r_valid) begin
            case (i_bc.func)
                FN_ADD: begin
                    n_pick    = in_lo && in_hi;
                    n_partial = in_lo != in_hi;
                    n_encl    = (i_bc.vfirst <= r_first) && (r_last <= i_bc.vend);
                end
                FN_LOOKUP: begin
                    n_pick    = in_lo && in_hi;
                    n_partial = in_lo != in_hi;
                end
                FN_REMOVE: begin
                    n_pick = i_bc.slot == i_idx;
                end
                default: begin
                    n_pick = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.set && i_wr.idx == i_idx) begin
            r_valid <= 1'b1;
        end else if (i_wr.clr && i_wr.idx == i_idx) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.set && i_wr.idx == i_idx) begin
            r_first <= i_wr.first;
            r_last  <= i_wr.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick    <= 1'b0;
            r_partial <= 1'b0;
            r_encl    <= 1'b0;
        end else if (i_bc.cmp_en) begin
            r_pick    <= n_pick;
            r_partial <= n_partial;
            r_encl    <= n_encl;
        end
    end

    // The lowest picking cell wins; a second pick further down sets the multi flag.
    always_comb begin
        o_link           = i_link;
        o_link.multi     = i_link.multi | (i_link.hit & r_pick);
        o_link.err       = i_link.err | r_partial | r_encl;
        if (!i_link.hit && r_pick) begin
            o_link.hit       = 1'b1;
            o_link.hit_idx   = i_idx;
            o_link.hit_first = r_first;
            o_link.hit_last  = r_last;
        end
        if (!i_link.free && !r_valid) begin
            o_link.free     = 1'b1;
            o_link.free_idx = i_idx;
        end
    end

    assign o_valid = r_valid;

endmodule

// ----- hdl/address_region_table_unit.sv -----
// Top level of the address region table: handshakes, configuration port,
// sequencer and the chain of table cells. Depends on art_pkg and art_cell.
//
//  Port group     Direction  Handshake                Carries
//  input item     in         i_in_valid / o_in_ready  func, addresses, pages, perms, kind, slot
//  result item    out        o_out_valid / i_out_ready status, found, slot, bounds, flags
//  configuration  in         psel / penable / pready  kernel_space (0x0), high_limit (0x8)
//
// An item goes through accept, a compare cycle in which every cell
// checks its entry in parallel, and a result cycle in which the scan chain
// settles and the table is updated. The next item is accepted in the cycle
// after the result is loaded into the output register. If that register
// still holds an untaken result, the block waits in the result cycle.
// Reset empties the table at once and restores the register defaults.
module address_region_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [art_pkg::FUNC_W-1:0]        i_func,
    input  logic [art_pkg::ADDR_W-1:0]        i_virt_first,
    input  logic [art_pkg::ADDR_W-1:0]        i_virt_last,
    input  logic [art_pkg::PAGES_W-1:0]       i_pages,
    input  logic                              i_perm_read,
    input  logic                              i_perm_write,
    input  logic                              i_perm_exec,
    input  logic [art_pkg::KIND_W-1:0]        i_backing_kind,
    input  logic [art_pkg::SLOT_W-1:0]        i_slot_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [art_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_found,
    output logic [art_pkg::SLOT_W-1:0]        o_slot_out,
    output logic [art_pkg::ADDR_W-1:0]        o_region_first,
    output logic [art_pkg::ADDR_W-1:0]        o_region_last,
    output logic                              o_flag_present,
    output logic                              o_flag_user,
    output logic                              o_flag_writable,
    output logic                              o_flag_no_exec,
    output logic                              o_flag_uncached,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [art_pkg::PADDR_W-1:0]       paddr,
    input  logic [art_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [art_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import art_pkg::*;

    // Configuration registers.
    logic              r_kernel_space;
    logic [ADDR_W-1:0] r_high_limit;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_space <= 1'b0;
            r_high_limit   <= HIGH_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[PADDR_W-1]) begin
                r_high_limit <= pwdata[ADDR_W-1:0];
            end else begin
                r_kernel_space <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[PADDR_W-1]) begin
            prdata = CFG_DATA_W'(r_high_limit);
        end else begin
            prdata = CFG_DATA_W'(r_kernel_space);
        end
    end

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_cmp_en;
    logic   w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_RES;
            S_RES:   if (!o_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_cmp_en   = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_CMP:   w_cmp_en = 1'b1;
            S_RES:   w_load = !o_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Captured item.
    t_func              r_func;
    logic [ADDR_W-1:0]  r_vfirst;
    logic [ADDR_W-1:0]  r_vlast;
    logic [PAGES_W-1:0] r_pages;
    logic               r_pr;
    logic               r_pw;
    logic               r_px;
    logic [KIND_W-1:0]  r_kind;
    logic [SLOT_W-1:0]  r_slot;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= t_func'(i_func);
            r_vfirst <= i_virt_first;
            r_vlast  <= i_virt_last;
            r_pages  <= i_pages;
            r_pr     <= i_perm_read;
            r_pw     <= i_perm_write;
            r_px     <= i_perm_exec;
            r_kind   <= i_backing_kind;
            r_slot   <= i_slot_in;
        end
    end

    // End address of an add, with its overflow and limit check.
    logic [SUM_W-1:0]  w_sum;
    logic [ADDR_W-1:0] w_end;
    logic              w_over;
    logic [ADDR_W-1:0] r_end;
    logic              r_over;

    assign w_sum  = SUM_W'(r_vfirst) + SUM_W'({r_pages, {PAGE_SHIFT{1'b0}}});
    assign w_end  = w_sum[ADDR_W-1:0];
    assign w_over = (|w_sum[SUM_W-1:ADDR_W]) || (w_end >= r_high_limit);

    always_ff @(posedge i_clk) begin
        if (w_cmp_en) begin
            r_end  <= w_end;
            r_over <= w_over;
        end
    end

    // Cell chain.
    t_bcast w_bc;
    t_wr    w_wr;
    t_link  w_link [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0] w_valid;

    always_comb begin
        w_bc.cmp_en = w_cmp_en;
        w_bc.func   = r_func;
        w_bc.lo     = r_vfirst & PAGE_MASK;
        w_bc.hi     = ((r_func == FN_ADD) ? w_end : r_vlast) & PAGE_MASK;
        w_bc.vfirst = r_vfirst;
        w_bc.vend   = w_end;
        w_bc.slot   = r_slot;
    end

    assign w_link[0] = '0;

    for (genvar gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
        art_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(gi)),
            .i_bc    (w_bc),
            .i_wr    (w_wr),
            .i_link  (w_link[gi]),
            .o_link  (w_link[gi+1]),
            .o_valid (w_valid[gi])
        );
    end

    t_link w_tail;
    assign w_tail = w_link[MAX_REGIONS];

    // Result decode.
    t_status           w_status;
    logic              w_found;
    logic [SLOT_W-1:0] w_slot;
    logic [ADDR_W-1:0] w_first;
    logic [ADDR_W-1:0] w_last;
    logic              w_add_ok;
    logic              w_rm_ok;
    logic              w_unaligned;

    assign w_unaligned = (|r_vfirst[PAGE_SHIFT-1:0]) || (|r_end[PAGE_SHIFT-1:0]);

    always_comb begin
        w_status = ST_OK;
        w_found  = 1'b0;
        w_slot   = '0;
        w_first  = '0;
        w_last   = '0;
        w_add_ok = 1'b0;
        w_rm_ok  = 1'b0;
        case (r_func)
            FN_ADD: begin
                if (r_over) begin
                    w_status = ST_HIGH_LIMIT;
                end else if (w_tail.err || w_tail.multi || w_tail.hit) begin
                    w_status = ST_CONFLICT;
                end else if (w_unaligned) begin
                    w_status = ST_UNALIGNED;
                end else if (!r_pr) begin
                    w_status = ST_NO_READ;
                end else if (!w_tail.free) begin
                    w_status = ST_FULL;
                end else begin
                    w_add_ok = 1'b1;
                    w_slot   = w_tail.free_idx;
                    w_first  = r_vfirst;
                    w_last   = r_end;
                end
            end
            FN_LOOKUP: begin
                w_status = (w_tail.err || w_tail.multi) ? ST_CONFLICT : ST_OK;
                if (w_tail.hit) begin
                    w_found = 1'b1;
                    w_slot  = w_tail.hit_idx;
                    w_first = w_tail.hit_first;
                    w_last  = w_tail.hit_last;
                end
            end
            FN_REMOVE: begin
                if (w_tail.hit) begin
                    w_rm_ok = 1'b1;
                    w_slot  = w_tail.hit_idx;
                    w_first = w_tail.hit_first;
                    w_last  = w_tail.hit_last;
                end else begin
                    w_status = ST_SLOT_EMPTY;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        w_wr.set   = w_load && w_add_ok;
        w_wr.clr   = w_load && w_rm_ok;
        w_wr.idx   = w_add_ok ? w_tail.free_idx : w_tail.hit_idx;
        w_wr.first = r_vfirst;
        w_wr.last  = r_end;
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status        <= w_status;
            o_found         <= w_found;
            o_slot_out      <= w_slot;
            o_region_first  <= w_first;
            o_region_last   <= w_last;
            o_flag_present  <= w_add_ok;
            o_flag_user     <= w_add_ok && !r_kernel_space;
            o_flag_writable <= w_add_ok && r_pw;
            o_flag_no_exec  <= w_add_ok && !r_px;
            o_flag_uncached <= w_add_ok && (r_kind == KIND_MMIO);
        end
    end

    assign o_out_valid = r_out_valid;

    // A successful add leaves its slot occupied.
    a_add_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.set |=> w_valid[$past(w_wr.idx)])
        else $error("added slot not valid");

    // The table changes by at most one entry per cycle.
    a_one_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) <= $past($countones(w_valid)) + 1) &&
        ($countones(w_valid) + 1 >= $past($countones(w_valid))))
        else $error("more than one table entry changed");

    // A full report only happens with every slot occupied.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_func == FN_ADD && w_status == ST_FULL) |-> (&w_valid))
        else $error("full reported with a free slot");

    // The table is only written when a result is loaded.
    a_write_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.set || w_wr.clr) |-> (r_state == S_RES && w_load))
        else $error("table written outside the result cycle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

// Testbench for address_region_table_unit. It checks adds, lookups and removes
// against a region table kept in the testbench, one result item per input item.
// Depends on art_pkg and the RTL of the block.
module tb;
    import art_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int WIN_PAGES   = 128;
    localparam int PHASE_ITEMS = 64;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 300;

    localparam logic [PADDR_W-1:0] REG_KERNEL_SPACE = 4'h0;
    localparam logic [PADDR_W-1:0] REG_HIGH_LIMIT   = 4'h8;

    localparam logic [KIND_W-1:0] KIND_SLICE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRESH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  vfirst;
        logic [ADDR_W-1:0]  vlast;
        logic [PAGES_W-1:0] pages;
        logic               rd;
        logic               wr;
        logic               ex;
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
    } t_table_op;

    typedef struct packed {
        t_status           status;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic              present;
        logic              user;
        logic              writable;
        logic              no_exec;
        logic              uncached;
    } t_table_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    t_table_op op_bus   = '0;

    logic                in_out_ready = 1'b0;
    logic                out_valid;
    logic [STATUS_W-1:0] out_status;
    logic                out_found;
    logic [SLOT_W-1:0]   out_slot;
    logic [ADDR_W-1:0]   out_first;
    logic [ADDR_W-1:0]   out_last;
    logic                out_present;
    logic                out_user;
    logic                out_writable;
    logic                out_no_exec;
    logic                out_uncached;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Region table as the testbench sees it.
    logic              tbl_valid [MAX_REGIONS];
    logic [ADDR_W-1:0] tbl_first [MAX_REGIONS];
    logic [ADDR_W-1:0] tbl_last  [MAX_REGIONS];
    logic              cfg_kernel     = 1'b0;
    logic [ADDR_W-1:0] cfg_high_limit = HIGH_LIMIT_RST;

    t_table_op  pending_ops [$];
    t_table_rsp expected_rsps [$];
    t_table_rsp want_rsp;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_on    = 1'b0;
    logic hold_off       = 1'b0;
    int   mismatch_count = 0;

    logic [ADDR_W-1:0] win_base = '0;

    address_region_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (op_bus.func),
        .i_virt_first    (op_bus.vfirst),
        .i_virt_last     (op_bus.vlast),
        .i_pages         (op_bus.pages),
        .i_perm_read     (op_bus.rd),
        .i_perm_write    (op_bus.wr),
        .i_perm_exec     (op_bus.ex),
        .i_backing_kind  (op_bus.kind),
        .i_slot_in       (op_bus.slot),
        .o_out_valid     (out_valid),
        .i_out_ready     (in_out_ready),
        .o_status        (out_status),
        .o_found         (out_found),
        .o_slot_out      (out_slot),
        .o_region_first  (out_first),
        .o_region_last   (out_last),
        .o_flag_present  (out_present),
        .o_flag_user     (out_user),
        .o_flag_writable (out_writable),
        .o_flag_no_exec  (out_no_exec),
        .o_flag_uncached (out_uncached),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Returns an error flag; hit is the lowest valid slot holding both ends, or -1.
    function automatic logic scan_regions(input logic [ADDR_W-1:0] lo,
                                          input logic [ADDR_W-1:0] hi,
                                          output int hit);
        logic has_lo;
        logic has_hi;
        logic err;
        err = 1'b0;
        hit = -1;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            if (tbl_valid[i]) begin
                has_lo = (tbl_first[i] <= lo) && (lo <= tbl_last[i]);
                has_hi = (tbl_first[i] <= hi) && (hi <= tbl_last[i]);
                if (has_lo && has_hi) begin
                    if (hit >= 0)
                        err = 1'b1;
                    else
                        hit = i;
                end
                if (has_lo != has_hi)
                    err = 1'b1;
            end
        end
        return err;
    endfunction

    // Applies one operation to the table copy and returns the result item it causes.
    function automatic t_table_rsp apply_op(input t_table_op op);
        t_table_rsp r;
        logic [ADDR_W:0] span;
        logic [ADDR_W:0] op_end;
        logic err;
        int hit;
        int free_slot;
        r = '0;
        r.status = ST_OK;
        case (op.func)
            FN_ADD: begin
                span = {{(ADDR_W+1-PAGES_W){1'b0}}, op.pages};
                span = span << PAGE_SHIFT;
                op_end = {1'b0, op.vfirst} + span;
                if (op_end[ADDR_W] || op_end[ADDR_W-1:0] >= cfg_high_limit) begin
                    r.status = ST_HIGH_LIMIT;
                end else begin
                    err = scan_regions(op.vfirst & PAGE_MASK, op_end[ADDR_W-1:0] & PAGE_MASK,
                                       hit);
                    // A new region may not enclose an existing one either.
                    for (int i = 0; i < MAX_REGIONS; i++)
                        if (tbl_valid[i] && op.vfirst <= tbl_first[i] &&
                            tbl_last[i] <= op_end[ADDR_W-1:0])
                            err = 1'b1;
                    if (err || hit >= 0) begin
                        r.status = ST_CONFLICT;
                    end else if (op.vfirst[PAGE_SHIFT-1:0] != 0 ||
                                 op_end[PAGE_SHIFT-1:0] != 0) begin
                        r.status = ST_UNALIGNED;
                    end else if (!op.rd) begin
                        r.status = ST_NO_READ;
                    end else begin
                        free_slot = -1;
                        for (int i = MAX_REGIONS - 1; i >= 0; i--)
                            if (!tbl_valid[i])
                                free_slot = i;
                        if (free_slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            tbl_valid[free_slot] = 1'b1;
                            tbl_first[free_slot] = op.vfirst;
                            tbl_last[free_slot]  = op_end[ADDR_W-1:0];
                            r.slot     = free_slot[SLOT_W-1:0];
                            r.first    = op.vfirst;
                            r.last     = op_end[ADDR_W-1:0];
                            r.present  = 1'b1;
                            r.user     = !cfg_kernel;
                            r.writable = op.wr;
                            r.no_exec  = !op.ex;
                            r.uncached = (op.kind == KIND_MMIO);
                        end
                    end
                end
            end
            FN_LOOKUP: begin
                err = scan_regions(op.vfirst & PAGE_MASK, op.vlast & PAGE_MASK, hit);
                if (err)
                    r.status = ST_CONFLICT;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = hit[SLOT_W-1:0];
                    r.first = tbl_first[hit];
                    r.last  = tbl_last[hit];
                end
            end
            FN_REMOVE: begin
                if (!tbl_valid[op.slot]) begin
                    r.status = ST_SLOT_EMPTY;
                end else begin
                    tbl_valid[op.slot] = 1'b0;
                    r.slot  = op.slot;
                    r.first = tbl_first[op.slot];
                    r.last  = tbl_last[op.slot];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed operations inside a small window so that regions collide,
    // lookups hit and the table fills up; the rest is noise over every field.
    function automatic t_table_op random_op();
        t_table_op op;
        logic [63:0] bits;
        logic [ADDR_W-1:0] page_addr;
        logic [ADDR_W-1:0] span;
        int pick;
        op = '0;
        pick = $urandom_range(99);
        page_addr = ADDR_W'($urandom_range(WIN_PAGES - 1));
        page_addr = win_base + (page_addr << PAGE_SHIFT);
        if (pick < 10) begin
            bits = rand64();
            op.func   = t_func'(bits[1:0]);
            op.rd     = bits[2];
            op.wr     = bits[3];
            op.ex     = bits[4];
            op.kind   = bits[6:5];
            op.slot   = bits[10:7];
            op.vfirst = ADDR_W'(rand64());
            op.vlast  = ADDR_W'(rand64());
            op.pages  = PAGES_W'(rand64());
        end else if (pick < 50) begin
            op.func   = FN_ADD;
            op.vfirst = page_addr;
            if ($urandom_range(19) == 0)
                op.vfirst[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(4095, 1));
            op.pages = PAGES_W'($urandom_range(6));
            op.rd    = ($urandom_range(9) != 0);
            op.wr    = 1'($urandom_range(1));
            op.ex    = 1'($urandom_range(1));
            op.kind  = KIND_W'($urandom_range(3));
            op.vlast = ADDR_W'(rand64());
            op.slot  = SLOT_W'($urandom_range(15));
        end else if (pick < 82) begin
            op.func   = FN_LOOKUP;
            op.vfirst = page_addr | ADDR_W'($urandom_range(4095));
            span = ADDR_W'($urandom_range(6));
            span = (span << PAGE_SHIFT) | ADDR_W'($urandom_range(4095));
            op.vlast = op.vfirst + span;
            if ($urandom_range(9) == 0)
                op.vlast = ADDR_W'(rand64());
            op.pages = PAGES_W'(rand64());
        end else begin
            op.func   = FN_REMOVE;
            op.slot   = SLOT_W'($urandom_range(15));
            op.vfirst = ADDR_W'(rand64());
        end
        return op;
    endfunction

    task automatic queue_add(input logic [ADDR_W-1:0] first, input logic [PAGES_W-1:0] pages,
                             input logic rd, input logic wr, input logic ex,
                             input logic [KIND_W-1:0] kind);
        t_table_op op;
        op = '0;
        op.func   = FN_ADD;
        op.vfirst = first;
        op.pages  = pages;
        op.rd     = rd;
        op.wr     = wr;
        op.ex     = ex;
        op.kind   = kind;
        pending_ops.push_back(op);
    endtask

    task automatic queue_lookup(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        t_table_op op;
        op = '0;
        op.func   = FN_LOOKUP;
        op.vfirst = lo;
        op.vlast  = hi;
        pending_ops.push_back(op);
    endtask

    task automatic queue_remove(input logic [SLOT_W-1:0] slot);
        t_table_op op;
        op = '0;
        op.func = FN_REMOVE;
        op.slot = slot;
        pending_ops.push_back(op);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [ADDR_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = '0;
        data[ADDR_W-1:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_KERNEL_SPACE)
            cfg_kernel = value[0];
        else
            cfg_high_limit = value;
    endtask

    // Sampled at the falling edge, after the driver and monitor have settled.
    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_rsps.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: offers the next pending item once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_rsps.push_back(apply_op(op_bus));
            if (!in_valid || in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    op_bus   <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result item against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_out_ready <= 1'b0;
        end else begin
            if (out_valid && in_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(out_status), '0);
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    check_field("status", 64'(out_status), 64'(want_rsp.status));
                    check_field("found", 64'(out_found), 64'(want_rsp.found));
                    check_field("slot_out", 64'(out_slot), 64'(want_rsp.slot));
                    check_field("region_first", 64'(out_first), 64'(want_rsp.first));
                    check_field("region_last", 64'(out_last), 64'(want_rsp.last));
                    check_field("flag_present", 64'(out_present), 64'(want_rsp.present));
                    check_field("flag_user", 64'(out_user), 64'(want_rsp.user));
                    check_field("flag_writable", 64'(out_writable), 64'(want_rsp.writable));
                    check_field("flag_no_exec", 64'(out_no_exec), 64'(want_rsp.no_exec));
                    check_field("flag_uncached", 64'(out_uncached), 64'(want_rsp.uncached));
                end
            end
            in_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so that the block backs up and stalls its input.
    initial begin
        wait (pressure_on);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("tb: errors");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit_cfg;
        logic kern_cfg;
        t_table_op op;

        for (int i = 0; i < MAX_REGIONS; i++)
            tbl_valid[i] = 1'b0;
        base = 48'h0000_0010_0000;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, with the register defaults.
        queue_add(base, PAGES_W'(4), 1'b1, 1'b1, 1'b0, KIND_MMIO);
        queue_add(base + 'h10000, '0, 1'b1, 1'b0, 1'b1, KIND_OTHER);
        queue_add(base + 'h1000, PAGES_W'(1), 1'b1, 1'b1, 1'b1, KIND_SLICE);
        queue_add(base - 'h1000, PAGES_W'('h20), 1'b1, 1'b0, 1'b0, KIND_FRESH);
        queue_add(base + 'h20123, PAGES_W'(1), 1'b1, 1'b1, 1'b1, KIND_FRESH);
        queue_add(base + 'h30000, PAGES_W'(1), 1'b0, 1'b1, 1'b1, KIND_FRESH);
        queue_add(48'hFFFF_FFFF_F000, PAGES_W'(1), 1'b1, 1'b1, 1'b1, KIND_SLICE);
        queue_add(48'h7FFF_FFFF_F000, PAGES_W'(1), 1'b1, 1'b1, 1'b1, KIND_SLICE);
        queue_add(48'h7FFF_FFFF_E000, PAGES_W'(1), 1'b1, 1'b1, 1'b1, KIND_SLICE);
        queue_add('0, '1, 1'b1, 1'b1, 1'b1, KIND_FRESH);
        queue_lookup(base + 'h123, base + 'h2FFF);
        queue_lookup(base + 'h4000, base + 'h4FFF);
        queue_lookup(base + 'h3000, base + 'h10000);
        queue_lookup(base + 'h50000, base + 'h60000);
        queue_lookup('0, '1);
        queue_lookup(48'h7FFF_FFFF_E000, 48'h7FFF_FFFF_FFFF);
        queue_remove(SLOT_W'(5));
        queue_remove(SLOT_W'(1));
        queue_remove(SLOT_W'(1));
        op = '1;
        op.func = FN_NONE;
        pending_ops.push_back(op);
        queue_lookup(base + 'h10000, base + 'h10000);
        queue_remove(SLOT_W'(2));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            win_base = ADDR_W'(rand64());
            win_base = win_base & PAGE_MASK;
            win_base[ADDR_W-1] = 1'b0;
            kern_cfg = p[0];
            limit_cfg = HIGH_LIMIT_RST;
            case (p)
                1: limit_cfg = '1;
                2: limit_cfg = '0;
                3: limit_cfg = ADDR_W'(rand64());
                5: limit_cfg = win_base + ADDR_W'('h1000 * (WIN_PAGES / 2));
                default: limit_cfg = HIGH_LIMIT_RST;
            endcase
            apb_write(REG_KERNEL_SPACE, ADDR_W'(kern_cfg));
            apb_write(REG_HIGH_LIMIT, limit_cfg);
            case (p)
                1: begin
                    send_idle_pct  <= 74;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 74;
                end
                3, 5: begin
                    send_idle_pct  <= 13;
                    recv_stall_pct <= 13;
                end
                default: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
            endcase
            if (p == 4)
                pressure_on <= 1'b1;
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_ops.push_back(random_op());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (expected_rsps.size() != 0)
            report_mismatch("results never seen", 64'(expected_rsps.size()), '0);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
